/* hw/rtl/ebd_pkg.sv */
// Shared constants, types and codes for the escaped back-reference decompressor.
package ebd_pkg;

   localparam int HISTORY_DEPTH_DEF = 256;
   localparam int OUT_LANES         = 4;
   localparam int LANE_W            = $clog2(OUT_LANES);
   localparam int COUNT_W           = 3;
   localparam int RSP_DATA_W        = ((OUT_LANES * 8 + COUNT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W         = RSP_DATA_W - OUT_LANES * 8 - COUNT_W;
   localparam int HEADER_BYTES      = 12;
   localparam int KEY_POSITION      = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COPY,
      ST_FLUSH
   } ebd_state_type;

   typedef enum logic [1:0] {
      PH_PLAIN,
      PH_KEY,
      PH_OFFSET
   } ebd_phase_type;

   typedef enum logic [1:0] {
      END_RUNNING,
      END_BODY,
      END_SIZE,
      END_OVERRUN
   } ebd_end_type;

endpackage

/* hw/rtl/ebd_history.sv */
// History window RAM: one write and one registered read per cycle, write-through on a hit.
module ebd_history #(
   parameter int  HISTORY_DEPTH = ebd_pkg::HISTORY_DEPTH_DEF,
   localparam int ADDR_W        = $clog2(HISTORY_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] hist_mem [HISTORY_DEPTH];
   logic [7:0] rd_raw_ff;
   logic       fwd_hit_ff;
   logic [7:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      rd_raw_ff   <= hist_mem[rd_addr];
      // read of the entry written in the same cycle sees the new byte
      fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
      fwd_data_ff <= wr_data;
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_raw_ff;

endmodule

/* hw/rtl/escaped_backref_decompressor.sv */
// Top level: header parse, token decode, history copy engine and result packing.
//
//  channel | dir | tdata                          | tuser            | tlast
//  req     | in  | in_byte                        | start_of_stream  | -
//  rsp     | out | out_byte0..3, out_count, pad   | end_status       | last_of_run
//
// Header, literal and key bytes are accepted while idle with a free output slot. A copy of length n
// holds the input from its length byte on: the history read is primed, one byte a cycle goes
// through the history RAM, the final beat is posted. Output backpressure stalls the copy engine.
// Synchronous reset; the history RAM is not cleared, emitted_ff acts as a fill
// count so that reads before the first written byte return zero.
module escaped_backref_decompressor #(
   parameter int HISTORY_DEPTH = ebd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] in_byte
   input  logic                          req_tuser,   // start_of_stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ebd_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_byte0..3, out_count, zero pad
   output logic                          rsp_tlast,   // last_of_run
   output logic [1:0]                    rsp_tuser    // end_status
);
   import ebd_pkg::*;

   localparam int ADDR_W = $clog2(HISTORY_DEPTH);
   localparam logic [ADDR_W:0]   DEPTH_V  = (ADDR_W + 1)'(HISTORY_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_PTR = ADDR_W'(HISTORY_DEPTH - 1);
   localparam logic [COUNT_W-1:0] FILL_FULL = COUNT_W'(OUT_LANES);

   ebd_state_type state_ff, state_in;
   logic [3:0]    hp_ff, hp_in;
   logic [31:0]   limit_ff, limit_in;
   logic [31:0]   body_ff, body_in;
   logic [7:0]    key_ff, key_in;
   ebd_phase_type phase_ff, phase_in;
   logic [7:0]    off_ff, off_in;
   logic [31:0]   emitted_ff, emitted_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic          finished_ff, finished_in;
   logic [7:0]    len_ff, len_in;
   logic          body_end_ff, body_end_in;
   logic          primed_ff, primed_in;
   logic [OUT_LANES-1:0][7:0] lanes_ff, lanes_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_LANES-1:0][7:0] rsp_bytes_ff, rsp_bytes_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_last_ff, rsp_last_in;
   ebd_end_type               rsp_status_ff, rsp_status_in;

   logic              slot_free, acc;
   logic [7:0]        b;
   logic              copy_start, copy_emit, copy_last;
   logic              push;
   logic [OUT_LANES-1:0][7:0] push_bytes;
   logic [COUNT_W-1:0] push_count;
   logic              push_last;
   ebd_end_type       push_status;
   logic              we;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wdata;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic [ADDR_W:0]   wp_w, off_w;
   logic [ADDR_W-1:0] wp_inc;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign acc        = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign wp_inc     = (wp_ff == LAST_PTR) ? '0 : wp_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc && copy_start) state_in = ST_COPY;
         end
         ST_COPY: begin
            if (copy_emit && copy_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result push
   always_comb begin
      logic        emit1;
      logic        tok_done;
      logic        ending;
      ebd_end_type status;
      logic [7:0]  emit_val;
      logic [7:0]  copy_val;
      logic [31:0] body_dec;
      logic [31:0] body_calc;

      hp_in       = hp_ff;
      limit_in    = limit_ff;
      body_in     = body_ff;
      key_in      = key_ff;
      phase_in    = phase_ff;
      off_in      = off_ff;
      emitted_in  = emitted_ff;
      wp_in       = wp_ff;
      finished_in = finished_ff;
      len_in      = len_ff;
      body_end_in = body_end_ff;
      lanes_in    = lanes_ff;
      fill_in     = fill_ff;

      copy_start  = 1'b0;
      copy_emit   = 1'b0;
      copy_last   = 1'b0;
      push        = 1'b0;
      push_bytes  = '0;
      push_count  = '0;
      push_last   = 1'b0;
      push_status = END_RUNNING;
      we          = 1'b0;
      wr_addr     = wp_ff;
      wdata       = '0;

      emit1     = 1'b0;
      tok_done  = 1'b0;
      ending    = 1'b0;
      status    = END_RUNNING;
      emit_val  = b;
      copy_val  = '0;
      body_dec  = body_ff - 32'd1;
      body_calc = (body_ff > 32'(HEADER_BYTES)) ? body_ff - 32'(HEADER_BYTES) : '0;

      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_tuser) begin
                  hp_in       = 4'd1;
                  limit_in    = {24'd0, b};
                  body_in     = '0;
                  key_in      = '0;
                  phase_in    = PH_PLAIN;
                  off_in      = '0;
                  emitted_in  = '0;
                  wp_in       = '0;
                  finished_in = 1'b0;
               end else if (finished_ff) begin
                  finished_in = 1'b1;
               end else if (hp_ff < 4'(HEADER_BYTES)) begin
                  hp_in = hp_ff + 4'd1;
                  for (int k = 0; k < 4; k++) begin
                     if (hp_ff == 4'(k))     limit_in[8*k +: 8] = b;
                     if (hp_ff == 4'(k + 4)) body_in[8*k +: 8]  = b;
                  end
                  if (hp_ff == 4'(KEY_POSITION)) key_in = b;
                  if (hp_ff == 4'(HEADER_BYTES - 1)) begin
                     body_in = body_calc;
                     if (body_calc == '0) begin
                        ending = 1'b1;
                        status = END_BODY;
                     end else if (limit_ff == '0) begin
                        ending = 1'b1;
                        status = END_SIZE;
                     end
                  end
               end else begin
                  body_in = body_dec;
                  case (phase_ff)
                     PH_KEY: begin
                        if (b == key_ff) begin
                           emit1    = 1'b1;
                           emit_val = key_ff;
                           tok_done = 1'b1;
                           phase_in = PH_PLAIN;
                        end else begin
                           off_in   = (b > key_ff) ? b - 8'd1 : b;
                           phase_in = PH_OFFSET;
                        end
                     end
                     PH_OFFSET: begin
                        phase_in = PH_PLAIN;
                        if (({1'b0, emitted_ff} + {25'd0, b}) > {1'b0, limit_ff}) begin
                           ending = 1'b1;
                           status = END_OVERRUN;
                        end else if (b != 8'd0) begin
                           copy_start  = 1'b1;
                           len_in      = b;
                           body_end_in = (body_dec == '0);
                           lanes_in    = '0;
                           fill_in     = '0;
                        end else begin
                           tok_done = 1'b1;
                        end
                     end
                     default: begin
                        if (b != key_ff) begin
                           emit1    = 1'b1;
                           tok_done = 1'b1;
                           phase_in = PH_PLAIN;
                        end else begin
                           phase_in = PH_KEY;
                        end
                     end
                  endcase

                  if (emit1) begin
                     we         = 1'b1;
                     wdata      = emit_val;
                     wp_in      = wp_inc;
                     emitted_in = emitted_ff + 32'd1;
                  end
                  // the size check of a copy waits for the flush
                  if (!ending && !copy_start) begin
                     if (body_dec == '0) begin
                        ending = 1'b1;
                        status = END_BODY;
                     end else if (tok_done && (emitted_in >= limit_ff)) begin
                        ending = 1'b1;
                        status = END_SIZE;
                     end
                  end
               end

               if (!copy_start && (emit1 || ending)) begin
                  push          = 1'b1;
                  push_bytes[0] = emit1 ? emit_val : 8'd0;
                  push_count    = emit1 ? COUNT_W'(1) : '0;
                  push_last     = 1'b1;
                  push_status   = status;
               end
               if (ending) finished_in = 1'b1;
            end
         end

         ST_COPY: begin
            copy_val  = ((off_ff == 8'd0) || ({24'd0, off_ff} > emitted_ff)) ? 8'd0 : rd_data;
            copy_emit = primed_ff && ((fill_ff != FILL_FULL) || slot_free);
            copy_last = (len_ff == 8'd1);
            if (copy_emit) begin
               we         = 1'b1;
               wdata      = copy_val;
               wp_in      = wp_inc;
               emitted_in = emitted_ff + 32'd1;
               len_in     = len_ff - 8'd1;
               if (fill_ff == FILL_FULL) begin
                  // full group goes out only once a further byte proves it is not the last
                  push        = 1'b1;
                  push_bytes  = lanes_ff;
                  push_count  = FILL_FULL;
                  lanes_in    = '0;
                  lanes_in[0] = copy_val;
                  fill_in     = COUNT_W'(1);
               end else begin
                  lanes_in[fill_ff[LANE_W-1:0]] = copy_val;
                  fill_in = fill_ff + 1'b1;
               end
            end
         end

         ST_FLUSH: begin
            if (body_end_ff)                  status = END_BODY;
            else if (emitted_ff >= limit_ff)  status = END_SIZE;
            if (slot_free) begin
               push        = 1'b1;
               push_bytes  = lanes_ff;
               push_count  = fill_ff;
               push_last   = 1'b1;
               push_status = status;
               fill_in     = '0;
               finished_in = (status != END_RUNNING);
            end
         end

         default: ;
      endcase
   end

   // read address for the byte after the one emitted this cycle
   assign wp_w  = {1'b0, wp_in};
   assign off_w = {{(ADDR_W - 7){1'b0}}, off_ff};
   always_comb begin
      logic [ADDR_W:0] addr_w;
      addr_w  = (wp_w >= off_w) ? wp_w - off_w : wp_w + DEPTH_V - off_w;
      rd_addr = addr_w[ADDR_W-1:0];
   end

   assign primed_in = (state_ff == ST_COPY) && (state_in == ST_COPY);

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_bytes_in  = push_bytes;
         rsp_count_in  = push_count;
         rsp_last_in   = push_last;
         rsp_status_in = push_status;
      end else if (rsp_tready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hp_ff        <= '0;
         limit_ff     <= '0;
         body_ff      <= '0;
         key_ff       <= '0;
         phase_ff     <= PH_PLAIN;
         off_ff       <= '0;
         emitted_ff   <= '0;
         wp_ff        <= '0;
         finished_ff  <= 1'b0;
         fill_ff      <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hp_ff        <= hp_in;
         limit_ff     <= limit_in;
         body_ff      <= body_in;
         key_ff       <= key_in;
         phase_ff     <= phase_in;
         off_ff       <= off_in;
         emitted_ff   <= emitted_in;
         wp_ff        <= wp_in;
         finished_ff  <= finished_in;
         fill_ff      <= fill_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      body_end_ff   <= body_end_in;
      lanes_ff      <= lanes_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   ebd_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wr_addr),
      .wr_data (wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_bytes_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
